// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sail force RTL.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SSPF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define SSPF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/sspf_pkg.sv =====
// Package for the solar sail pressure force block: register map, reset values, widths.
// No dependencies.
package sspf_pkg;

   localparam int VEC_W    = 32;
   localparam int COEF_W   = 17;
   localparam int WIDE_W   = 32;
   localparam int FORCE_W  = 52;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int DIV_W    = 35;
   localparam int CAL_W    = 6;

   // Calibration sequence: operand load, DIV_W divide steps, then a settle phase.
   localparam logic [CAL_W-1:0] CAL_LOAD   = CAL_W'(1 + DIV_W + 4);
   localparam logic [CAL_W-1:0] CAL_SETTLE = CAL_W'(5);

   localparam logic [COEF_W-1:0] Q16_ONE = COEF_W'(65536);
   localparam logic [50:0] FORCE_LIMIT = 51'(64'd1 << 50);

   localparam logic [COEF_W-1:0] RST_REFLECT = COEF_W'(58982);
   localparam logic [COEF_W-1:0] RST_SPEC    = COEF_W'(65536);
   localparam logic [COEF_W-1:0] RST_FRONT_B = COEF_W'(52429);
   localparam logic [COEF_W-1:0] RST_BACK_B  = COEF_W'(36045);
   localparam logic [COEF_W-1:0] RST_FRONT_E = COEF_W'(3277);
   localparam logic [COEF_W-1:0] RST_BACK_E  = COEF_W'(41943);
   localparam logic [WIDE_W-1:0] RST_AREA    = WIDE_W'(65536);
   localparam logic [WIDE_W-1:0] RST_PRESS   = WIDE_W'(298844160);

   typedef enum logic [2:0] {
      REG_REFLECT = 3'd0,
      REG_SPEC    = 3'd1,
      REG_FRONT_B = 3'd2,
      REG_BACK_B  = 3'd3,
      REG_FRONT_E = 3'd4,
      REG_BACK_E  = 3'd5,
      REG_AREA    = 3'd6,
      REG_PRESS   = 3'd7
   } csr_addr_type;

   function automatic logic [VEC_W-1:0] mag32(input logic [VEC_W-1:0] x);
      return x[VEC_W-1] ? (~x + VEC_W'(1)) : x;
   endfunction

endpackage

// ===== rtl/solar_sail_pressure_force.sv =====
// Solar sail pressure force: a registered pipeline from request accept to rsp_tvalid.
// Throughput one request per cycle outside calibration and rsp stalls; a stalled rsp side freezes the whole pipeline.
// After reset and after each register write a coefficient calculation runs
// (serial gamma divide, one quotient bit a cycle); req_tready stays low meanwhile.
// Reset is synchronous, active high; registers return to their documented defaults.
module solar_sail_pressure_force (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // normal_x, normal_y, normal_z, sun_x, sun_y, sun_z (32 bits each, lowest first)
   input  logic [191:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // force_x, force_y, force_z (52 bits each, lowest first), 4 zero pad bits
   output logic [159:0]        rsp_tdata,
   // bad_emissivity, saturated (lowest first)
   output logic [1:0]          rsp_tuser,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [sspf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [sspf_pkg::DATA_W-1:0] csr_pwdata,
   output logic [sspf_pkg::DATA_W-1:0] csr_prdata,
   output logic                csr_pready
);

   `include "assert_macros.svh"

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [16:0] rho_ff, spec_ff, bf_ff, bb_ff, ef_ff, eb_ff;
   logic [31:0] area_ff, press_ff;
   logic        csr_wr;
   sspf_pkg::csr_addr_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = sspf_pkg::csr_addr_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff   <= sspf_pkg::RST_REFLECT;
         spec_ff  <= sspf_pkg::RST_SPEC;
         bf_ff    <= sspf_pkg::RST_FRONT_B;
         bb_ff    <= sspf_pkg::RST_BACK_B;
         ef_ff    <= sspf_pkg::RST_FRONT_E;
         eb_ff    <= sspf_pkg::RST_BACK_E;
         area_ff  <= sspf_pkg::RST_AREA;
         press_ff <= sspf_pkg::RST_PRESS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            sspf_pkg::REG_REFLECT: rho_ff   <= csr_pwdata[16:0];
            sspf_pkg::REG_SPEC:    spec_ff  <= csr_pwdata[16:0];
            sspf_pkg::REG_FRONT_B: bf_ff    <= csr_pwdata[16:0];
            sspf_pkg::REG_BACK_B:  bb_ff    <= csr_pwdata[16:0];
            sspf_pkg::REG_FRONT_E: ef_ff    <= csr_pwdata[16:0];
            sspf_pkg::REG_BACK_E:  eb_ff    <= csr_pwdata[16:0];
            sspf_pkg::REG_AREA:    area_ff  <= csr_pwdata;
            sspf_pkg::REG_PRESS:   press_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sspf_pkg::REG_REFLECT: csr_prdata = {15'd0, rho_ff};
         sspf_pkg::REG_SPEC:    csr_prdata = {15'd0, spec_ff};
         sspf_pkg::REG_FRONT_B: csr_prdata = {15'd0, bf_ff};
         sspf_pkg::REG_BACK_B:  csr_prdata = {15'd0, bb_ff};
         sspf_pkg::REG_FRONT_E: csr_prdata = {15'd0, ef_ff};
         sspf_pkg::REG_BACK_E:  csr_prdata = {15'd0, eb_ff};
         sspf_pkg::REG_AREA:    csr_prdata = area_ff;
         sspf_pkg::REG_PRESS:   csr_prdata = press_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Coefficient calculation: gamma by restoring divide, then a1, a2, a3
   // and P*A through three register stages.
   // ------------------------------------------------------------------
   logic [5:0]  cal_cnt_ff, cal_cnt_in;
   logic        cal_busy;
   logic [33:0] num_pos, num_sub;
   logic [33:0] num_mag;
   logic        num_neg;
   logic [17:0] den;
   logic        bad_emis;
   logic [34:0] dq_ff;
   logic [17:0] rem_ff;
   logic [17:0] div_den_ff;
   logic        div_neg_ff;
   logic [18:0] trial;
   logic        trial_ge;

   assign num_pos  = 34'(ef_ff * bf_ff);
   assign num_sub  = 34'(eb_ff * bb_ff);
   assign num_neg  = num_sub > num_pos;
   assign num_mag  = num_neg ? (num_sub - num_pos) : (num_pos - num_sub);
   assign den      = 18'(ef_ff) + 18'(eb_ff);
   assign bad_emis = (den == 18'd0);
   assign cal_busy = (cal_cnt_ff != 6'd0);

   assign trial    = {rem_ff, dq_ff[34]};
   assign trial_ge = trial >= {1'b0, div_den_ff};

   always_comb begin
      cal_cnt_in = cal_cnt_ff;
      if (csr_wr)
         cal_cnt_in = sspf_pkg::CAL_LOAD;
      else if (cal_busy)
         cal_cnt_in = cal_cnt_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         cal_cnt_ff <= sspf_pkg::CAL_LOAD;
      else
         cal_cnt_ff <= cal_cnt_in;
   end

   // Load operands, then shift in one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (cal_cnt_ff == sspf_pkg::CAL_LOAD) begin
         dq_ff      <= {1'b0, num_mag};
         rem_ff     <= '0;
         div_den_ff <= den;
         div_neg_ff <= num_neg;
      end else if (cal_cnt_ff >= sspf_pkg::CAL_SETTLE) begin
         rem_ff <= trial_ge ? 18'(trial - {1'b0, div_den_ff}) : trial[17:0];
         dq_ff  <= {dq_ff[33:0], trial_ge};
      end
   end

   logic [34:0] gam_mag;
   logic [17:0] omr_mag;
   logic        omr_neg;
   logic [16:0] oms_mag;
   logic        oms_neg;

   assign gam_mag = bad_emis ? 35'd0 : dq_ff;
   assign omr_neg = rho_ff > sspf_pkg::Q16_ONE;
   assign omr_mag = omr_neg ? 18'(rho_ff - sspf_pkg::Q16_ONE)
                            : 18'(sspf_pkg::Q16_ONE - rho_ff);
   assign oms_neg = spec_ff > sspf_pkg::Q16_ONE;
   assign oms_mag = oms_neg ? (spec_ff - sspf_pkg::Q16_ONE) : (sspf_pkg::Q16_ONE - spec_ff);

   logic [33:0] a3p_ff, bfr_ff;
   logic [63:0] pap_ff;
   logic [17:0] a3_ff;
   logic [34:0] t1_ff;
   logic        t1_neg_ff;
   logic [52:0] t2_ff;
   logic        t2_neg_ff;
   logic [47:0] pak_ff;
   logic [18:0] a1_mag_ff;
   logic        a1_neg_ff;
   // |gamma| stays below 2^17, so |a2| stays below 2^19 for any register value
   logic [18:0] a2_mag_ff;
   logic        a2_neg_ff;
   logic [17:0] a3k_ff;
   logic [47:0] pa_ff;
   logic signed [38:0] a2_sum;
   logic signed [19:0] a1_sum;

   always_comb begin
      a2_sum = (t1_neg_ff ? -39'(t1_ff[34:16]) : 39'(t1_ff[34:16]))
             + (t2_neg_ff ? -39'(t2_ff[52:16]) : 39'(t2_ff[52:16]));
      a1_sum = 20'(sspf_pkg::Q16_ONE) - 20'(a3_ff);
   end

   always_ff @(posedge clock) begin
      // first products
      a3p_ff    <= 34'(rho_ff * spec_ff);
      bfr_ff    <= 34'(bf_ff * rho_ff);
      pap_ff    <= 64'(press_ff * area_ff);
      // scaled products
      a3_ff     <= a3p_ff[33:16];
      t1_ff     <= 35'(bfr_ff[33:16] * oms_mag);
      t1_neg_ff <= oms_neg;
      t2_ff     <= 53'(omr_mag * gam_mag);
      t2_neg_ff <= omr_neg ^ div_neg_ff;
      pak_ff    <= pap_ff[63:16];
      // final coefficients as sign and magnitude
      a1_neg_ff <= a1_sum[19];
      a1_mag_ff <= a1_sum[19] ? 19'(-a1_sum) : 19'(a1_sum);
      a2_neg_ff <= a2_sum[38];
      a2_mag_ff <= a2_sum[38] ? 19'(-a2_sum) : 19'(a2_sum);
      a3k_ff    <= a3_ff;
      pa_ff     <= pak_ff;
   end

   // ------------------------------------------------------------------
   // Force pipeline: stage 0 captures the request, stage 9 is the
   // response register. All stages advance together.
   // ------------------------------------------------------------------
   logic       adv;
   logic [8:0] vld_ff;
   logic       out_vld_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv && !cal_busy;
   assign rsp_tvalid = out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[7:0], req_tvalid && req_tready};
         out_vld_ff <= vld_ff[8];
      end
   end

   // Vectors ride along until stage 5; stage 6 forms their products with the coefficients.
   logic [31:0] n_ff [0:5][0:2];
   logic [31:0] u_ff [0:5][0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[0][i] <= req_tdata[32*i +: 32];
            u_ff[0][i] <= req_tdata[96 + 32*i +: 32];
            for (int s = 1; s < 6; s++) begin
               n_ff[s][i] <= n_ff[s-1][i];
               u_ff[s][i] <= u_ff[s-1][i];
            end
         end
      end
   end

   // Stage 1: per-axis products of n and u.
   logic [63:0] pm1_ff [0:2];
   logic        pn1_ff [0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pm1_ff[i] <= 64'(sspf_pkg::mag32(n_ff[0][i]) * sspf_pkg::mag32(u_ff[0][i]));
            pn1_ff[i] <= n_ff[0][i][31] ^ u_ff[0][i][31];
         end
      end
   end

   // Stage 2: d = n.u in Q.30.
   logic signed [35:0] d_sum;
   logic signed [35:0] d2_ff;

   always_comb begin
      d_sum = '0;
      for (int i = 0; i < 3; i++)
         d_sum = pn1_ff[i] ? d_sum - 36'(pm1_ff[i][63:30]) : d_sum + 36'(pm1_ff[i][63:30]);
   end

   always_ff @(posedge clock) begin
      if (adv)
         d2_ff <= d_sum;
   end

   // Stage 3: d*d, a1*d, a2*d.
   logic [33:0] d_mag;
   logic [67:0] dd3_ff;
   logic [52:0] a1d3_ff;
   logic [52:0] a2d3_ff;
   logic        dneg3_ff;

   assign d_mag = d2_ff[35] ? 34'(-d2_ff) : 34'(d2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         dd3_ff   <= 68'(d_mag * d_mag);
         a1d3_ff  <= 53'(a1_mag_ff * d_mag);
         a2d3_ff  <= 53'(a2_mag_ff * d_mag);
         dneg3_ff <= d2_ff[35];
      end
   end

   // Stage 4: a3*d*d, and scale the others; cu = -a1*d.
   logic [55:0] a3dd4_ff;
   logic [36:0] cu4_ff;
   logic        cu4_neg_ff;
   logic [36:0] a2q4_ff;
   logic        a2q4_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a3dd4_ff    <= 56'(a3k_ff * dd3_ff[67:30]);
         cu4_ff      <= a1d3_ff[52:16];
         cu4_neg_ff  <= !(a1_neg_ff ^ dneg3_ff);
         a2q4_ff     <= a2d3_ff[52:16];
         a2q4_neg_ff <= a2_neg_ff ^ dneg3_ff;
      end
   end

   // Stage 5: cn = a2*d - 2*a3*d*d.
   logic signed [56:0] cn5_ff;
   logic [36:0]        cu5_ff;
   logic               cu5_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cn5_ff     <= (a2q4_neg_ff ? -57'(a2q4_ff) : 57'(a2q4_ff))
                     - 57'({a3dd4_ff[55:16], 1'b0});
         cu5_ff     <= cu4_ff;
         cu5_neg_ff <= cu4_neg_ff;
      end
   end

   // Stage 6: coefficient times vector; cn is split in two halves.
   logic [55:0] cn_mag;
   logic [59:0] cnlo6_ff [0:2];
   logic [59:0] cnhi6_ff [0:2];
   logic [68:0] cuu6_ff  [0:2];
   logic        cnn_neg6_ff [0:2];
   logic        cuu_neg6_ff [0:2];

   assign cn_mag = cn5_ff[56] ? 56'(-cn5_ff) : 56'(cn5_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cnlo6_ff[i]    <= 60'(cn_mag[27:0] * sspf_pkg::mag32(n_ff[5][i]));
            cnhi6_ff[i]    <= 60'(cn_mag[55:28] * sspf_pkg::mag32(n_ff[5][i]));
            cuu6_ff[i]     <= 69'(cu5_ff * sspf_pkg::mag32(u_ff[5][i]));
            cnn_neg6_ff[i] <= cn5_ff[56] ^ n_ff[5][i][31];
            cuu_neg6_ff[i] <= cu5_neg_ff ^ u_ff[5][i][31];
         end
      end
   end

   // Stage 7: v = cu*u + cn*n in Q.30.
   logic [87:0]        cnn_full [0:2];
   logic signed [59:0] v7_ff [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++)
         cnn_full[i] = {cnhi6_ff[i], 28'd0} + 88'(cnlo6_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            v7_ff[i] <= (cnn_neg6_ff[i] ? -60'(cnn_full[i][87:30]) : 60'(cnn_full[i][87:30]))
                      + (cuu_neg6_ff[i] ? -60'(cuu6_ff[i][68:30]) : 60'(cuu6_ff[i][68:30]));
      end
   end

   // Stage 8: P*A times v as four partial products.
   logic [58:0] v_mag [0:2];
   logic [53:0] pll8_ff [0:2];
   logic [53:0] plh8_ff [0:2];
   logic [52:0] phl8_ff [0:2];
   logic [52:0] phh8_ff [0:2];
   logic        vneg8_ff [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++)
         v_mag[i] = v7_ff[i][59] ? 59'(-v7_ff[i]) : 59'(v7_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pll8_ff[i]  <= 54'(v_mag[i][29:0] * pa_ff[23:0]);
            plh8_ff[i]  <= 54'(v_mag[i][29:0] * pa_ff[47:24]);
            phl8_ff[i]  <= 53'(v_mag[i][58:30] * pa_ff[23:0]);
            phh8_ff[i]  <= 53'(v_mag[i][58:30] * pa_ff[47:24]);
            vneg8_ff[i] <= v7_ff[i][59];
         end
      end
   end

   // Stage 9: sum, scale, clip to +-2^50 and restore the sign.
   logic [106:0] f_full [0:2];
   logic [76:0]  f_q [0:2];
   logic         f_sat [0:2];
   logic [50:0]  f_clip [0:2];
   logic [51:0]  force_ff [0:2];
   logic         sat_ff;
   logic         bad_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_full[i] = 107'(pll8_ff[i]) + {29'd0, plh8_ff[i], 24'd0}
                   + {24'd0, phl8_ff[i], 30'd0} + {phh8_ff[i], 54'd0};
         f_q[i]    = f_full[i][106:30];
         f_sat[i]  = (|f_q[i][76:51]) || (f_q[i][50] && (|f_q[i][49:0]));
         f_clip[i] = f_sat[i] ? sspf_pkg::FORCE_LIMIT : f_q[i][50:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            force_ff[i] <= vneg8_ff[i] ? -52'(f_clip[i]) : 52'(f_clip[i]);
         sat_ff <= f_sat[0] || f_sat[1] || f_sat[2];
         bad_ff <= bad_emis;
      end
   end

   assign rsp_tdata = {4'd0, force_ff[2], force_ff[1], force_ff[0]};
   assign rsp_tuser = {sat_ff, bad_ff};

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `SSPF_ASSERT(a_no_req_in_cal, cal_busy |-> !req_tready, "request taken during calibration")
   `SSPF_ASSERT(a_last_stage_moves, adv && vld_ff[8] |=> out_vld_ff, "pipeline item lost")
   `SSPF_ASSERT(a_bad_flag, out_vld_ff |-> (bad_ff == bad_emis), "emissivity flag mismatch")
   `SSPF_ASSERT_ALWAYS(a_reset_clears, reset |=> !out_vld_ff && cal_busy, "reset left state")

endmodule

// ===== tb/sv/tb_solar_sail_pressure_force.sv =====
// Testbench for the solar sail pressure force block: drives request vectors and CSR writes,
// predicts every response with a local fixed-point model and checks it field by field.
// Depends on sspf_pkg and solar_sail_pressure_force.
module tb_solar_sail_pressure_force;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
   localparam logic signed [31:0] Q30_NEG = -32'sd1073741824;
   localparam logic signed [63:0] FORCE_CLIP = 64'sd1 <<< 50;

   typedef struct packed {
      logic [51:0] force_x;
      logic [51:0] force_y;
      logic [51:0] force_z;
      logic        bad_emissivity;
      logic        saturated;
   } force_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [191:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [sspf_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [sspf_pkg::DATA_W-1:0] csr_pwdata = '0;
   logic [sspf_pkg::DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Sail coefficients as held by the predictor
   longint sail_coef [8];
   force_result_type expected_forces [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   solar_sail_pressure_force i_dut (.*);

   always #5 clock = ~clock;

   // Product scaled by 2^-k, truncated toward zero, clipped to the signed 64-bit range
   function automatic longint scale_mul(longint a, longint b, int k);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = 128'(signed'(a)) * 128'(signed'(b));
      q = (p < 0) ? -((-p) >>> k) : (p >>> k);
      if (q > 128'sh7FFF_FFFF_FFFF_FFFF) q = 128'sh7FFF_FFFF_FFFF_FFFF;
      if (q < -128'sh7FFF_FFFF_FFFF_FFFF) q = -128'sh7FFF_FFFF_FFFF_FFFF;
      return longint'(q);
   endfunction

   function automatic force_result_type predict_force(logic [191:0] vec);
      force_result_type r;
      longint nv [3];
      longint uv [3];
      longint dot, num, den, gamma, a1, a2, a3, cu, cn, pa, v, f;
      logic [51:0] comp [3];
      r = '0;
      for (int i = 0; i < 3; i++) begin
         nv[i] = longint'(signed'(vec[32*i +: 32]));
         uv[i] = longint'(signed'(vec[32*(i+3) +: 32]));
      end
      dot = 0;
      for (int i = 0; i < 3; i++) dot += scale_mul(nv[i], uv[i], 30);
      num = sail_coef[sspf_pkg::REG_FRONT_E] * sail_coef[sspf_pkg::REG_FRONT_B]
          - sail_coef[sspf_pkg::REG_BACK_E] * sail_coef[sspf_pkg::REG_BACK_B];
      den = sail_coef[sspf_pkg::REG_FRONT_E] + sail_coef[sspf_pkg::REG_BACK_E];
      if (den == 0) begin
         gamma = 0;
         r.bad_emissivity = 1'b1;
      end else begin
         gamma = num / den;
      end
      a3 = scale_mul(sail_coef[sspf_pkg::REG_REFLECT], sail_coef[sspf_pkg::REG_SPEC], 16);
      a1 = 65536 - a3;
      a2 = scale_mul(scale_mul(sail_coef[sspf_pkg::REG_FRONT_B],
                               sail_coef[sspf_pkg::REG_REFLECT], 16),
                     65536 - sail_coef[sspf_pkg::REG_SPEC], 16)
         + scale_mul(65536 - sail_coef[sspf_pkg::REG_REFLECT], gamma, 16);
      cu = -scale_mul(a1, dot, 16);
      cn = scale_mul(a2, dot, 16) - 2 * scale_mul(a3, scale_mul(dot, dot, 30), 16);
      pa = scale_mul(sail_coef[sspf_pkg::REG_PRESS], sail_coef[sspf_pkg::REG_AREA], 16);
      for (int i = 0; i < 3; i++) begin
         v = scale_mul(cu, uv[i], 30) + scale_mul(cn, nv[i], 30);
         f = scale_mul(pa, v, 30);
         if (f > FORCE_CLIP) begin
            f = FORCE_CLIP;
            r.saturated = 1'b1;
         end else if (f < -FORCE_CLIP) begin
            f = -FORCE_CLIP;
            r.saturated = 1'b1;
         end
         comp[i] = f[51:0];
      end
      r.force_x = comp[0];
      r.force_y = comp[1];
      r.force_z = comp[2];
      return r;
   endfunction

   // Send one request; the prediction is queued when the handshake completes.
   // Valid stays high afterwards so the next request can follow without a gap.
   task automatic send_request(logic [191:0] vec);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= vec;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_forces.push_back(predict_force(vec));
   endtask

   // Drop valid, hold until every response is back, then let the pipeline drain
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Two-phase APB write; mirror the register in the predictor
   task automatic write_csr(sspf_pkg::csr_addr_type idx, logic [31:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= sspf_pkg::ADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sail_coef[idx] = (idx == sspf_pkg::REG_AREA || idx == sspf_pkg::REG_PRESS)
                     ? longint'(value) : longint'(value[16:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [191:0] pack_vec(logic [31:0] nx, ny, nz, ux, uy, uz);
      return {uz, uy, ux, nz, ny, nx};
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(9))
         0: return Q30_ONE;
         1: return Q30_NEG;
         2: return $urandom();
         default: return 32'($signed($urandom_range(2147483647)) - 32'sd1073741823);
      endcase
   endfunction

   function automatic logic [191:0] rand_vec();
      return pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      rand_comp());
   endfunction

   // Receiver: stall at random and check each response against the oldest prediction
   always @(posedge clock) begin
      force_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_forces.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_count++;
            end else begin
               exp_r = expected_forces.pop_front();
               if (rsp_tdata[51:0] !== exp_r.force_x) begin
                  $error("force_x expected %h actual %h", exp_r.force_x, rsp_tdata[51:0]);
                  error_count++;
               end
               if (rsp_tdata[103:52] !== exp_r.force_y) begin
                  $error("force_y expected %h actual %h", exp_r.force_y, rsp_tdata[103:52]);
                  error_count++;
               end
               if (rsp_tdata[155:104] !== exp_r.force_z) begin
                  $error("force_z expected %h actual %h", exp_r.force_z, rsp_tdata[155:104]);
                  error_count++;
               end
               if (rsp_tuser[0] !== exp_r.bad_emissivity) begin
                  $error("bad_emissivity expected %b actual %b", exp_r.bad_emissivity,
                         rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tuser[1] !== exp_r.saturated) begin
                  $error("saturated expected %b actual %b", exp_r.saturated, rsp_tuser[1]);
                  error_count++;
               end
            end
         end
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Field extremes, axis-aligned and oblique geometry, out-of-range inputs
   task automatic test_directed_vectors();
      send_request(pack_vec(Q30_ONE, 0, 0, Q30_ONE, 0, 0));
      send_request(pack_vec(0, Q30_ONE, 0, 0, Q30_NEG, 0));
      send_request(pack_vec(0, 0, Q30_NEG, 0, 0, Q30_NEG));
      send_request(pack_vec(Q30_ONE, 0, 0, 0, Q30_ONE, 0));
      send_request(pack_vec(759250125, 759250125, 0, Q30_ONE, 0, 0));
      send_request('0);
      send_request({6{32'h8000_0000}});
      send_request({6{32'h7FFF_FFFF}});
      send_request(pack_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
      send_request({6{32'hAAAA_AAAA}});
      send_request({6{32'h5555_5555}});
   endtask

   // Zero emissivity sum forces gamma to zero and flags it
   task automatic test_zero_emissivity();
      write_csr(sspf_pkg::REG_FRONT_E, 0);
      write_csr(sspf_pkg::REG_BACK_E, 0);
      send_request(pack_vec(Q30_ONE, 0, 0, 759250125, 759250125, 0));
      send_request(rand_vec());
      write_csr(sspf_pkg::REG_FRONT_E, 32'h1_0000);
      write_csr(sspf_pkg::REG_BACK_E, 32'h1_0000);
      send_request(pack_vec(Q30_ONE, 0, 0, Q30_ONE, 0, 0));
   endtask

   // Huge pressure and area drive the force into the clip
   task automatic test_saturation();
      write_csr(sspf_pkg::REG_AREA, 32'hFFFF_FFFF);
      write_csr(sspf_pkg::REG_PRESS, 32'hFFFF_FFFF);
      send_request(pack_vec(Q30_ONE, 0, 0, Q30_ONE, 0, 0));
      send_request({6{32'h8000_0000}});
      send_request(pack_vec(Q30_NEG, 0, 0, Q30_ONE, 0, 0));
      write_csr(sspf_pkg::REG_AREA, 0);
      send_request(rand_vec());
   endtask

   // Random coefficient setting including extremes and the upper bits of each field
   task automatic randomize_coefs();
      for (int r = 0; r < 6; r++) begin
         case ($urandom_range(3))
            0: write_csr(sspf_pkg::csr_addr_type'(r), 0);
            1: write_csr(sspf_pkg::csr_addr_type'(r), 32'h1_0000);
            2: write_csr(sspf_pkg::csr_addr_type'(r), $urandom());
            default: write_csr(sspf_pkg::csr_addr_type'(r), $urandom_range(65536));
         endcase
      end
      write_csr(sspf_pkg::REG_AREA, ($urandom_range(3) == 0) ? $urandom()
                                                             : $urandom_range(1 << 22));
      write_csr(sspf_pkg::REG_PRESS, ($urandom_range(3) == 0) ? $urandom()
                                                              : $urandom_range(32'h2000_0000));
   endtask

   // Random vectors over the four idling phases, with new coefficients per phase
   task automatic test_random_phases();
      int idle_tbl [4] = '{0, 75, 0, 18};
      int stall_tbl [4] = '{0, 0, 75, 18};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tbl[ph];
         recv_stall_pct = stall_tbl[ph];
         randomize_coefs();
         for (int i = 0; i < 150; i++) begin
            send_request(rand_vec());
            // Pause the sender once midway through each phase until all responses are in
            if (i == 75) wait_drained();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) sail_coef[i] = 0;
      sail_coef[sspf_pkg::REG_REFLECT] = sspf_pkg::RST_REFLECT;
      sail_coef[sspf_pkg::REG_SPEC] = sspf_pkg::RST_SPEC;
      sail_coef[sspf_pkg::REG_FRONT_B] = sspf_pkg::RST_FRONT_B;
      sail_coef[sspf_pkg::REG_BACK_B] = sspf_pkg::RST_BACK_B;
      sail_coef[sspf_pkg::REG_FRONT_E] = sspf_pkg::RST_FRONT_E;
      sail_coef[sspf_pkg::REG_BACK_E] = sspf_pkg::RST_BACK_E;
      sail_coef[sspf_pkg::REG_AREA] = sspf_pkg::RST_AREA;
      sail_coef[sspf_pkg::REG_PRESS] = sspf_pkg::RST_PRESS;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_vectors();
      test_zero_emissivity();
      test_saturation();
      test_random_phases();
      wait_drained();
      if (error_count == 0 && expected_forces.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
